FILE: hw/rtl/pil_pkg.sv
// ----------------------------------------------------------------------------
// pil_pkg
// Shared types and constants of the positional list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pil_pkg;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_POS   = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pil_cell.sv
// ----------------------------------------------------------------------------
// pil_cell
// One storage cell of the list chain; shifts toward either neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module pil_cell
  import pil_pkg::*;
(
  input  wire logic             clk_i,
  input  wire cmd_t             cmd_i,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire logic [VAL_W-1:0] left_i,
  input  wire logic [VAL_W-1:0] right_i,
  input  wire logic [VAL_W-1:0] rem_i,
  output logic      [VAL_W-1:0] val_o,
  output logic      [VAL_W-1:0] rem_o
);

  logic [VAL_W-1:0] val_q;
  logic [VAL_W-1:0] val_d;
  logic             hit;

  assign hit = (cell_idx_i == cmd_i.idx);

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (hit) begin
        val_d = cmd_i.value;
      end else if (cell_idx_i > cmd_i.idx) begin
        val_d = left_i;
      end
    end else if (cmd_i.del) begin
      // close the gap: everything from the removed slot on pulls from the right
      if (cell_idx_i >= cmd_i.idx) begin
        val_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  // pass the addressed element down the chain
  assign rem_o = rem_i | (hit ? val_q : '0);

endmodule

`default_nettype wire

FILE: hw/rtl/pil_ctrl.sv
// ----------------------------------------------------------------------------
// pil_ctrl
// Request decode, element count, status and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pil_ctrl
  import pil_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [OP_W-1:0]   op_i,
  input  wire logic [VAL_W-1:0]  value_i,
  input  wire logic [POS_W-1:0]  pos_i,
  input  wire logic [VAL_W-1:0]  rem_val_i,
  output cmd_t                   cmd_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ST_W-1:0]        status_o,
  output logic [CNT_W-1:0]       count_o,
  output logic [VAL_W-1:0]       removed_o
);

  logic             accept;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  status_e          status_q, status_d;
  logic [CNT_W-1:0] res_count_q;
  logic [VAL_W-1:0] removed_q, removed_d;
  logic             full, empty;
  logic             do_ins, do_del;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] pos_idx;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full    = (count_q == CNT_W'(LIST_DEPTH));
  assign empty   = (count_q == '0);
  assign pos_idx = IDX_W'(pos_i - POS_W'(1));

  always_comb begin
    status_d = ST_OK;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    idx      = '0;
    case (op_e'(op_i))
      OP_INS_FRONT: begin
        if (full) status_d = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_END: begin
        idx = IDX_W'(count_q);
        if (full) status_d = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INS_POS: begin
        idx = pos_idx;
        if (full) status_d = ST_FULL;
        else if (pos_i == '0 || pos_i > count_q + CNT_W'(1)) status_d = ST_BADPOS;
        else do_ins = 1'b1;
      end
      OP_DEL_FRONT: begin
        if (empty) status_d = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_END: begin
        idx = IDX_W'(count_q - CNT_W'(1));
        if (empty) status_d = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_POS: begin
        idx = pos_idx;
        if (empty) status_d = ST_EMPTY;
        else if (pos_i == '0 || pos_i > count_q) status_d = ST_BADPOS;
        else do_del = 1'b1;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign cmd_o.ins   = accept && do_ins;
  assign cmd_o.del   = accept && do_del;
  assign cmd_o.idx   = idx;
  assign cmd_o.value = value_i;

  always_comb begin
    count_d = count_q;
    if (cmd_o.ins) count_d = count_q + CNT_W'(1);
    else if (cmd_o.del) count_d = count_q - CNT_W'(1);
  end

  assign removed_d = do_del ? rem_val_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      res_count_q <= count_d;
      removed_q   <= removed_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = res_count_q;
  assign removed_o   = removed_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIST_DEPTH))
    else $error("element count above list depth");

  a_ins_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not advance the count");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_FULL |-> res_count_q == CNT_W'(LIST_DEPTH))
    else $error("full status reported with room left");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && removed_q != '0 |-> status_q == ST_OK)
    else $error("removed value on a failed request");

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_unit
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis channel: an op code (insert front, insert
//   end, insert at position, delete front, delete end, delete at position),
//   a value and a 1-based position. Each request yields exactly one result
//   on the m_axis channel: status, element count after the request and the
//   removed value (zero unless a delete succeeded).
//   The result is registered at the edge that takes the request. All cells
//   shift in parallel in that same cycle, so one request per cycle is
//   sustained as long as results are taken. The single result register
//   decides the rate: while a result waits with m_axis_tready low,
//   s_axis_tready is low and no request is taken.
//   Reset clears the element count and the result valid; cell contents
//   are left as they are and only read once written by an insert.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete_unit
  import pil_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [2:0] op, [34:3] value, [39:35] position
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [1:0] status, [6:2] count, [38:7] removed_value, [39] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  cmd_t             cmd;
  logic [VAL_W-1:0] cell_val [LIST_DEPTH];
  logic [VAL_W-1:0] rem_chain [LIST_DEPTH+1];
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] count;
  logic [VAL_W-1:0] removed;

  assign rem_chain[0] = '0;

  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;

    if (k == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = cell_val[k-1];
    end

    if (k == LIST_DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = cell_val[k+1];
    end

    pil_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .cell_idx_i (IDX_W'(k)),
      .left_i     (left_val),
      .right_i    (right_val),
      .rem_i      (rem_chain[k]),
      .val_o      (cell_val[k]),
      .rem_o      (rem_chain[k+1])
    );
  end

  pil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tdata[2:0]),
    .value_i     (s_axis_tdata[34:3]),
    .pos_i       (s_axis_tdata[39:35]),
    .rem_val_i   (rem_chain[LIST_DEPTH]),
    .cmd_o       (cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .count_o     (count),
    .removed_o   (removed)
  );

  assign m_axis_tdata = {1'b0, removed, count, status};

endmodule

`default_nettype wire
